>>> rtl/core/ttmc_pkg.sv
// shared types, codes and widths for the tape transport mode controller
package ttmc_pkg;

   localparam int ModeW = 4;
   localparam int KeyW  = 4;
   localparam int OptW  = 16;
   localparam int CmdW  = 4;

   // transport modes
   localparam logic [ModeW-1:0] M_STOP  = 4'd0;
   localparam logic [ModeW-1:0] M_PLAYF = 4'd1;
   localparam logic [ModeW-1:0] M_PLAYR = 4'd2;
   localparam logic [ModeW-1:0] M_REC   = 4'd3;
   localparam logic [ModeW-1:0] M_FFD   = 4'd4;
   localparam logic [ModeW-1:0] M_REW   = 4'd5;
   localparam logic [ModeW-1:0] M_AFFD  = 4'd6;
   localparam logic [ModeW-1:0] M_AREW  = 4'd7;
   localparam logic [ModeW-1:0] M_PAUSE = 4'd8;

   // extra transport commands
   localparam logic [CmdW-1:0] C_NONE  = 4'd0;
   localparam logic [CmdW-1:0] C_CAPF  = 4'd10;
   localparam logic [CmdW-1:0] C_CAPR  = 4'd11;
   localparam logic [CmdW-1:0] C_ASTOP = 4'd12;

   // key codes, internal ones above mute
   localparam logic [KeyW-1:0] K_NONE    = 4'd0;
   localparam logic [KeyW-1:0] K_STOP    = 4'd1;
   localparam logic [KeyW-1:0] K_PLAYF   = 4'd2;
   localparam logic [KeyW-1:0] K_PLAYR   = 4'd3;
   localparam logic [KeyW-1:0] K_PLAY    = 4'd4;
   localparam logic [KeyW-1:0] K_REC     = 4'd5;
   localparam logic [KeyW-1:0] K_PAUSE   = 4'd6;
   localparam logic [KeyW-1:0] K_FFD     = 4'd7;
   localparam logic [KeyW-1:0] K_REW     = 4'd8;
   localparam logic [KeyW-1:0] K_ROLL    = 4'd9;
   localparam logic [KeyW-1:0] K_REV     = 4'd10;
   localparam logic [KeyW-1:0] K_MUTE    = 4'd11;
   localparam logic [KeyW-1:0] K_PROGHLD = 4'd12;
   localparam logic [KeyW-1:0] K_UNROLL  = 4'd13;

   // programming phases
   localparam logic [1:0] P_OFF   = 2'd0;
   localparam logic [1:0] P_ONE   = 2'd1;
   localparam logic [1:0] P_TWO   = 2'd2;
   localparam logic [1:0] P_ARMED = 2'd3;

   // record path requests
   localparam logic [1:0] R_SAME = 2'd0;
   localparam logic [1:0] R_OFF  = 2'd1;
   localparam logic [1:0] R_ON   = 2'd2;

   // option bits
   localparam int O_ARCH = 0;
   localparam int O_RECPLAY = 1;
   localparam int O_PLAYEXIT = 2;
   localparam int O_RECPAUSE = 3;
   localparam int O_PLAYREC = 4;
   localparam int O_MUTEPAUSE = 5;
   localparam int O_CUEARCH = 6;
   localparam int O_CUEROLL = 7;
   localparam int O_PROG = 8;
   localparam int O_AUTOREV = 9;
   localparam int O_NOSOUND = 10;

   // register address of the options register
   localparam logic [1:0] A_OPTIONS = 2'd0;

   typedef struct packed {
      logic [ModeW-1:0] cur_mode;
      logic [ModeW-1:0] return_mode;
      logic             pause_flag;
      logic             roll_flag;
      logic [1:0]       prog_state;
      logic [ModeW-1:0] prog_first;
      logic [ModeW-1:0] prog_second;
      logic [ModeW-1:0] reverse_mode;
      logic             autostop_flag;
      logic             refresh_flag;
   } state_type;

   typedef struct packed {
      logic             kind;
      logic [KeyW-1:0]  key;
      logic             released;
      logic             held;
      logic             capstan_reverse;
      logic [1:0]       autostop_cause;
      logic             prog_timer_over;
      logic             transport_stopped;
      logic             tape_moving;
      logic             low_tension;
   } item_type;

   typedef struct packed {
      logic [CmdW-1:0]  transport_cmd;
      logic             cue_on;
      logic [1:0]       rec_path;
      logic             mute_toggle;
      logic [1:0]       sound;
      logic             reverse_delay;
      logic [ModeW-1:0] mode_now;
      logic             paused;
      logic             rolling;
      logic [1:0]       prog_phase;
      logic [ModeW-1:0] prog_second;
      logic             display_update;
   } result_type;

   // wind mode, archive variant when the option is set
   function automatic logic [ModeW-1:0] wound(input logic [ModeW-1:0] m,
                                              input logic arch);
      logic [ModeW-1:0] r;
      r = m;
      if (m == M_FFD && arch) r = M_AFFD;
      if (m == M_REW && arch) r = M_AREW;
      return r;
   endfunction

   function automatic logic [CmdW-1:0] drive(input logic [ModeW-1:0] m);
      return m + 4'd1;
   endfunction

endpackage

>>> rtl/core/ttmc_logic.sv
// next-state and result logic for one key event or service tick
module ttmc_logic (
   input  ttmc_pkg::state_type  st,
   input  ttmc_pkg::item_type   item,
   input  logic [ttmc_pkg::OptW-1:0] opts,
   output ttmc_pkg::state_type  st_next,
   output ttmc_pkg::result_type res
);
   import ttmc_pkg::*;

   always_comb begin
      state_type s;
      logic [KeyW-1:0] k;
      logic [CmdW-1:0] cmd;
      logic cue, mute, rdel, served, pdone;
      logic [1:0] rec, snd;
      logic [ModeW-1:0] f;
      logic arch, nosnd;

      s = st;
      cmd = C_NONE; cue = 1'b0; mute = 1'b0; rdel = 1'b0;
      rec = R_SAME; snd = 2'b00; served = 1'b0; pdone = 1'b0;
      arch = opts[O_ARCH];
      nosnd = opts[O_NOSOUND];
      k = K_NONE;
      f = M_STOP;

      if (!item.kind) begin
         // key filtering
         k = (item.key > K_MUTE) ? K_NONE : item.key;
         if (k != K_NONE) begin
            if (k == K_PLAY) k = item.capstan_reverse ? K_PLAYR : K_PLAYF;
            if (item.released) k = (k == K_ROLL) ? K_UNROLL : K_NONE;
            else if (item.held) k = (k == K_STOP) ? K_PROGHLD : K_NONE;
         end
         if (k != K_NONE) begin
            if (!nosnd) snd[0] = 1'b1;
            // two-step programming
            if (opts[O_PROG]) begin
               if (s.cur_mode != M_STOP) begin
                  if (k == K_PLAYR || k == K_PLAYF || k == K_REW || k == K_FFD ||
                      k == K_REC || k == K_STOP || k == K_REV) begin
                     s.prog_state = P_OFF; s.prog_first = M_STOP;
                     s.prog_second = M_STOP; s.refresh_flag = 1'b1;
                  end
               end else if (k == K_PROGHLD && s.prog_state == P_OFF) begin
                  s.prog_state = P_ONE; s.prog_first = M_STOP;
                  s.prog_second = M_STOP; s.refresh_flag = 1'b1;
               end else if (k == K_STOP && s.prog_state != P_OFF) begin
                  s.prog_state = P_OFF; s.prog_first = M_STOP;
                  s.prog_second = M_STOP; s.refresh_flag = 1'b1;
               end else if (s.prog_state == P_ONE) begin
                  if (k == K_PLAYR) s.prog_first = M_PLAYR;
                  else if (k == K_REW) s.prog_first = wound(M_REW, arch);
                  else if (k == K_FFD) s.prog_first = wound(M_FFD, arch);
                  else if (k == K_PLAYF) s.prog_first = M_PLAYF;
                  else if (k == K_PAUSE || k == K_REC || k == K_ROLL) begin
                     if (!nosnd) snd[1] = 1'b1;
                     k = K_STOP;
                  end
                  if (s.prog_first != M_STOP) begin
                     k = K_STOP; s.prog_state = P_TWO; s.refresh_flag = 1'b1;
                  end
               end else if (s.prog_state == P_TWO) begin
                  f = s.prog_first;
                  if (f == M_AREW && k == K_REW) begin
                     s.prog_first = M_REW; k = K_STOP; pdone = 1'b1;
                  end else if (f == M_AFFD && k == K_FFD) begin
                     s.prog_first = M_FFD; k = K_STOP; pdone = 1'b1;
                  end
                  if (!pdone) begin
                     if (f == M_AREW || f == M_REW || f == M_PLAYR) begin
                        if (k == K_PLAYF) s.prog_second = M_PLAYF;
                        else if (k == K_FFD) s.prog_second = wound(M_FFD, arch);
                        else if (k == K_PAUSE) s.prog_second = M_PAUSE;
                        else if (k == K_PLAYR || k == K_REW || k == K_REC ||
                                 k == K_ROLL) begin
                           if (!nosnd) snd[1] = 1'b1;
                           k = K_STOP;
                        end
                     end
                     if (f == M_AFFD || f == M_FFD || f == M_PLAYF) begin
                        if (k == K_PLAYR) s.prog_second = M_PLAYR;
                        else if (k == K_REW) s.prog_second = wound(M_REW, arch);
                        else if (k == K_PAUSE) s.prog_second = M_PAUSE;
                        else if (k == K_PLAYF || k == K_FFD || k == K_REC ||
                                 k == K_ROLL) begin
                           if (!nosnd) snd[1] = 1'b1;
                           k = K_STOP;
                        end
                     end
                     if (s.prog_second != M_STOP) begin
                        k = K_STOP; s.prog_state = P_ARMED; s.refresh_flag = 1'b1;
                     end
                  end
               end else if (s.prog_state == P_ARMED) begin
                  if (s.prog_second == M_AREW && k == K_REW) begin
                     s.prog_second = M_REW; k = K_STOP;
                  end else if (s.prog_second == M_AFFD && k == K_FFD) begin
                     s.prog_second = M_FFD; k = K_STOP;
                  end else if (k == K_PLAYR || k == K_PLAYF || k == K_REW ||
                               k == K_FFD || k == K_REC || k == K_ROLL) begin
                     if (!nosnd) snd[1] = 1'b1;
                     k = K_STOP;
                  end
               end
            end

            // mode rules
            case (k)
               K_STOP: begin
                  s.cur_mode = M_STOP; s.pause_flag = 1'b0; rec = R_OFF;
                  cmd = drive(M_STOP);
               end
               K_PLAYF, K_PLAYR: begin
                  if (s.cur_mode == M_REC) begin
                     if (opts[O_RECPLAY]) begin
                        s.cur_mode = (k == K_PLAYF) ? M_PLAYF : M_PLAYR;
                        rec = R_OFF;
                     end
                     if (k == K_PLAYF && opts[O_PLAYEXIT]) s.pause_flag = 1'b0;
                  end else begin
                     s.cur_mode = (k == K_PLAYF) ? M_PLAYF : M_PLAYR;
                     if (opts[O_PLAYEXIT]) s.pause_flag = 1'b0;
                  end
                  if (!s.pause_flag) cmd = drive(s.cur_mode);
                  else begin
                     cmd = (k == K_PLAYF) ? C_CAPF : C_CAPR;
                     cue = 1'b1;
                  end
               end
               K_REC: begin
                  if (s.cur_mode == M_STOP || (s.cur_mode == M_PLAYF &&
                      (s.pause_flag || opts[O_PLAYREC]))) begin
                     s.cur_mode = M_REC;
                     if (opts[O_RECPAUSE]) s.pause_flag = 1'b1;
                     rec = R_ON;
                     cmd = s.pause_flag ? C_CAPF : drive(M_REC);
                  end
               end
               K_PAUSE: begin
                  s.pause_flag = !s.pause_flag;
                  if (s.pause_flag) begin
                     if (s.cur_mode != M_PLAYF && s.cur_mode != M_PLAYR &&
                         s.cur_mode != M_REC) s.cur_mode = M_STOP;
                     cmd = drive(M_PAUSE);
                     if (!opts[O_MUTEPAUSE]) cue = 1'b1;
                  end else begin
                     cmd = drive(s.cur_mode);
                  end
               end
               K_FFD, K_REW: begin
                  s.pause_flag = 1'b0;
                  if (k == K_FFD)
                     s.cur_mode = (s.cur_mode == M_AFFD) ? M_FFD : wound(M_FFD, arch);
                  else
                     s.cur_mode = (s.cur_mode == M_AREW) ? M_REW : wound(M_REW, arch);
                  rec = R_OFF;
                  cmd = drive(s.cur_mode);
               end
               K_ROLL: begin
                  if (s.cur_mode == M_REC) begin
                     rec = R_OFF; s.cur_mode = M_PLAYF;
                  end
                  if (s.cur_mode == M_PLAYF) begin
                     s.return_mode = s.cur_mode; s.cur_mode = wound(M_REW, arch);
                     s.roll_flag = 1'b1;
                  end else if (s.cur_mode == M_PLAYR) begin
                     s.return_mode = s.cur_mode; s.cur_mode = wound(M_FFD, arch);
                     s.roll_flag = 1'b1;
                  end else if (s.cur_mode == M_AFFD || s.cur_mode == M_AREW) begin
                     if (opts[O_CUEARCH]) cue = 1'b1;
                  end
                  if (s.roll_flag) begin
                     cmd = drive(s.cur_mode);
                     if (opts[O_CUEROLL]) cue = 1'b1;
                  end
               end
               K_UNROLL: begin
                  if (s.roll_flag) begin
                     s.cur_mode = s.return_mode; s.roll_flag = 1'b0;
                  end
                  cmd = drive(s.cur_mode);
               end
               K_REV: begin
                  if (s.cur_mode == M_PLAYF) begin
                     s.cur_mode = M_PLAYR;
                     cmd = s.pause_flag ? C_CAPR : drive(M_PLAYR);
                  end else if (s.cur_mode == M_PLAYR) begin
                     s.cur_mode = M_PLAYF;
                     cmd = s.pause_flag ? C_CAPF : drive(M_PLAYF);
                  end else if (s.cur_mode != M_REC) begin
                     cmd = item.capstan_reverse ? C_CAPF : C_CAPR;
                  end
               end
               K_MUTE: mute = 1'b1;
               default: ;
            endcase
            s.refresh_flag = 1'b1;
            s.autostop_flag = 1'b0;
         end
         served = s.refresh_flag;
      end else begin
         // service tick
         served = s.refresh_flag;
         s.refresh_flag = 1'b0;
         if (item.autostop_cause != 2'd0) begin
            if (!s.autostop_flag && item.autostop_cause == 2'd1) begin
               if (s.cur_mode == M_PLAYF) s.reverse_mode = M_PLAYR;
               else if (s.cur_mode == M_PLAYR) s.reverse_mode = M_PLAYF;
               else s.reverse_mode = M_STOP;
               s.autostop_flag = 1'b1;
            end
            s.cur_mode = M_STOP;
            cmd = C_ASTOP;
            s.refresh_flag = 1'b1;
         end
         if (item.prog_timer_over) begin
            if (s.prog_state == P_ARMED) begin
               s.cur_mode = s.prog_first;
               s.prog_first = M_STOP;
               cmd = drive(s.cur_mode);
            end else begin
               if (!nosnd) snd[0] = 1'b1;
               s.prog_first = M_STOP;
               s.prog_second = M_STOP;
            end
            s.prog_state = P_OFF;
            s.refresh_flag = 1'b1;
         end
         if (s.autostop_flag && item.transport_stopped) begin
            if (!(item.tape_moving || item.low_tension)) begin
               if (s.prog_second != M_STOP) begin
                  s.cur_mode = s.prog_second;
                  s.prog_second = M_STOP;
                  cmd = drive(s.cur_mode);
                  s.refresh_flag = 1'b1;
               end else if (opts[O_AUTOREV] && s.reverse_mode != M_STOP) begin
                  s.cur_mode = s.reverse_mode;
                  cmd = drive(s.cur_mode);
                  rdel = 1'b1;
                  s.refresh_flag = 1'b1;
               end
            end
            s.autostop_flag = 1'b0;
         end
         served = served | s.refresh_flag;
      end

      st_next = s;
      res.transport_cmd  = cmd;
      res.cue_on         = cue;
      res.rec_path       = rec;
      res.mute_toggle    = mute;
      res.sound          = snd;
      res.reverse_delay  = rdel;
      res.mode_now       = s.cur_mode;
      res.paused         = s.pause_flag;
      res.rolling        = s.roll_flag;
      res.prog_phase     = s.prog_state;
      res.prog_second    = s.prog_second;
      res.display_update = served;
   end

endmodule

>>> rtl/core/tape_transport_mode_controller.sv
// tape transport mode controller top level: handshake, state and options registers
// the result of an accepted transaction is registered at the edge that accepts it
// throughput: one transaction per cycle while the result is not stalled, set by the single state register update
// a new transaction is taken while a result waits, as long as the result is not stalled
// reset (synchronous, active high) sets all modes to stop, flags clear, refresh pending
// and options to zero; the result register empties
module tape_transport_mode_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [3:0]  req_key,
   input  logic        req_released,
   input  logic        req_held,
   input  logic        req_capstan_reverse,
   input  logic [1:0]  req_autostop_cause,
   input  logic        req_prog_timer_over,
   input  logic        req_transport_stopped,
   input  logic        req_tape_moving,
   input  logic        req_low_tension,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_transport_cmd,
   output logic        rsp_cue_on,
   output logic [1:0]  rsp_rec_path,
   output logic        rsp_mute_toggle,
   output logic [1:0]  rsp_sound,
   output logic        rsp_reverse_delay,
   output logic [3:0]  rsp_mode_now,
   output logic        rsp_paused,
   output logic        rsp_rolling,
   output logic [1:0]  rsp_prog_phase,
   output logic [3:0]  rsp_prog_second,
   output logic        rsp_display_update,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ttmc_pkg::*;

   state_type           state_ff, state_in, st_calc;
   result_type          res_ff, res_calc;
   logic                rvalid_ff;
   logic [OptW-1:0]     opts_ff;
   item_type            item;
   logic                take, cfg_wr;

   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && (csr_paddr == A_OPTIONS);
   assign csr_prdata = (csr_paddr == A_OPTIONS) ? {16'd0, opts_ff} : 32'd0;

   // input stalls only when the result register is full and stalled
   assign req_stall = rvalid_ff && rsp_stall;
   assign take = req_valid && !req_stall;

   assign item = '{kind: req_kind, key: req_key, released: req_released,
                   held: req_held, capstan_reverse: req_capstan_reverse,
                   autostop_cause: req_autostop_cause,
                   prog_timer_over: req_prog_timer_over,
                   transport_stopped: req_transport_stopped,
                   tape_moving: req_tape_moving, low_tension: req_low_tension};

   ttmc_logic u_logic (
      .st      (state_ff),
      .item    (item),
      .opts    (opts_ff),
      .st_next (st_calc),
      .res     (res_calc)
   );

   // state update, options write also requests a refresh
   always_comb begin
      state_in = state_ff;
      if (take) state_in = st_calc;
      if (cfg_wr) state_in.refresh_flag = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{cur_mode: M_STOP, return_mode: M_STOP, pause_flag: 1'b0,
                       roll_flag: 1'b0, prog_state: P_OFF, prog_first: M_STOP,
                       prog_second: M_STOP, reverse_mode: M_STOP,
                       autostop_flag: 1'b0, refresh_flag: 1'b1};
         opts_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cfg_wr) opts_ff <= csr_pwdata[OptW-1:0];
         if (take) rvalid_ff <= 1'b1;
         else if (!rsp_stall) rvalid_ff <= 1'b0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (take) res_ff <= res_calc;
   end

   assign rsp_valid          = rvalid_ff;
   assign rsp_transport_cmd  = res_ff.transport_cmd;
   assign rsp_cue_on         = res_ff.cue_on;
   assign rsp_rec_path       = res_ff.rec_path;
   assign rsp_mute_toggle    = res_ff.mute_toggle;
   assign rsp_sound          = res_ff.sound;
   assign rsp_reverse_delay  = res_ff.reverse_delay;
   assign rsp_mode_now       = res_ff.mode_now;
   assign rsp_paused         = res_ff.paused;
   assign rsp_rolling        = res_ff.rolling;
   assign rsp_prog_phase     = res_ff.prog_phase;
   assign rsp_prog_second    = res_ff.prog_second;
   assign rsp_display_update = res_ff.display_update;

   // a result is held while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(res_ff))
      else $error("result changed while stalled");

   // an accepted transaction always produces a result
   a_take: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid)
      else $error("accepted transaction gave no result");

   // sound is silent when disabled
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      take && opts_ff[O_NOSOUND] |=> rsp_sound == 2'b00)
      else $error("sound with sound off");

endmodule
